// ===== design/error_diffusion_dither_rgb_top_assert.svh =====
// Assertion macros used by the dither back end
`ifndef ERROR_DIFFUSION_DITHER_RGB_TOP_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_RGB_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle
`define EDD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle
`define EDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/edd_pkg.sv =====
// Shared constants and types of the error diffusion dither block
package edd_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CNT_W     = COL_W + 1;
	localparam int IMGW_W    = 11;
	localparam int CMP_W     = (CNT_W > IMGW_W) ? CNT_W : IMGW_W;

	// Pixel and error widths
	localparam int PIX_W    = 8;
	localparam int LEVEL_W  = 8;
	localparam int ERR_W    = 10;
	localparam int CHANNELS = 3;
	localparam int LINE_W   = CHANNELS * ERR_W;
	localparam int SUM_W    = 12;
	localparam int PROD_W   = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef logic [COL_W-1:0]           col_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [CMP_W-1:0]           cmp_t;
	typedef logic [PIX_W-1:0]           pix8_t;
	typedef logic [PROD_W-1:0]          prod_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [ERR_W-1:0]    err_t;
	typedef err_t [CHANNELS-1:0]        err_rgb_t;

	localparam cnt_t FILL_MAX = cnt_t'(MAX_WIDTH);

	// One input pixel as it travels through the queue
	typedef struct packed {
		pix8_t blue;
		pix8_t green;
		pix8_t red;
		logic  frame_start;
	} pix_t;

	// Head of the queue as seen by the back end
	typedef struct packed {
		logic valid;
		pix_t pix;
	} qhead_t;

	// Effective configuration
	typedef struct packed {
		logic [LEVEL_W-1:0] levels;
		pix8_t              step;
		cnt_t               width;
	} cfg_t;

endpackage

// ===== design/error_diffusion_dither_rgb_top.sv =====
// Top level of the Floyd-Steinberg RGB dither with its configuration registers
//
// Takes 24-bit RGB pixels in raster order and returns one dithered pixel per input
// pixel, in order. The back end steps each pixel through take and line read, sum
// and level multiply, quantise and error spread, one pixel at a time, since error
// feeds from one pixel to the next through that sequencer. A two-entry input queue
// and an output register let the input side and the output side stall on their
// own. The next-row error line is a 1024 x 30-bit RAM; a fill count marks which
// columns have been written since the last frame start, so no clearing pass is
// needed and pixels are accepted straight after reset. Write levels_minus_one
// (index 0) and image_width (index 1) only while no pixel is in flight.
module error_diffusion_dither_rgb_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [edd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        blue_in,
	input  logic [7:0]                        green_in,
	input  logic [7:0]                        red_in,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        blue_out,
	output logic [7:0]                        green_out,
	output logic [7:0]                        red_out
);

	logic [edd_pkg::LEVEL_W-1:0]  levels_q;
	edd_pkg::pix8_t               step_q;
	logic [edd_pkg::IMGW_W-1:0]   width_q;
	edd_pkg::cmp_t                width_ext;
	edd_pkg::cmp_t                width_eff;
	edd_pkg::cfg_t                cfg;
	edd_pkg::qhead_t              head;
	logic                         pop;

	// Level spacing floor(255 / n), zero levels taken as one
	function automatic edd_pkg::pix8_t step_of(input logic [7:0] n);
		case (n) inside
			[8'd128:8'd255]: step_of = 8'd1;
			[8'd86:8'd127]:  step_of = 8'd2;
			[8'd64:8'd85]:   step_of = 8'd3;
			[8'd52:8'd63]:   step_of = 8'd4;
			[8'd43:8'd51]:   step_of = 8'd5;
			[8'd37:8'd42]:   step_of = 8'd6;
			[8'd32:8'd36]:   step_of = 8'd7;
			[8'd29:8'd31]:   step_of = 8'd8;
			[8'd26:8'd28]:   step_of = 8'd9;
			[8'd24:8'd25]:   step_of = 8'd10;
			[8'd22:8'd23]:   step_of = 8'd11;
			[8'd20:8'd21]:   step_of = 8'd12;
			8'd19:           step_of = 8'd13;
			8'd18:           step_of = 8'd14;
			[8'd16:8'd17]:   step_of = 8'd15;
			8'd15:           step_of = 8'd17;
			8'd14:           step_of = 8'd18;
			8'd13:           step_of = 8'd19;
			8'd12:           step_of = 8'd21;
			8'd11:           step_of = 8'd23;
			8'd10:           step_of = 8'd25;
			8'd9:            step_of = 8'd28;
			8'd8:            step_of = 8'd31;
			8'd7:            step_of = 8'd36;
			8'd6:            step_of = 8'd42;
			8'd5:            step_of = 8'd51;
			8'd4:            step_of = 8'd63;
			8'd3:            step_of = 8'd85;
			8'd2:            step_of = 8'd127;
			default:         step_of = 8'd255;
		endcase
	endfunction

	// Register configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= 8'd1;
			step_q   <= 8'd255;
			width_q  <= 11'd640;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				edd_pkg::REG_LEVELS: begin
					levels_q <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
					step_q   <= step_of(cfg_data[7:0]);
				end
				edd_pkg::REG_WIDTH: begin
					width_q <= cfg_data;
				end
				default: begin
					levels_q <= levels_q;
				end
			endcase
		end
	end

	// Clamp the row width into the line store
	assign width_ext = edd_pkg::cmp_t'(width_q);
	always_comb begin
		if (width_ext == '0) begin
			width_eff = edd_pkg::cmp_t'(1);
		end else if (width_ext > edd_pkg::cmp_t'(edd_pkg::MAX_WIDTH)) begin
			width_eff = edd_pkg::cmp_t'(edd_pkg::MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		cfg.levels = levels_q;
		cfg.step   = step_q;
		cfg.width  = edd_pkg::cnt_t'(width_eff);
	end

	edd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.blue_in    (blue_in),
		.green_in   (green_in),
		.red_in     (red_in),
		.frame_start(frame_start),
		.head       (head),
		.pop        (pop)
	);

	edd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.blue_out (blue_out),
		.green_out(green_out),
		.red_out  (red_out)
	);

endmodule

// ===== design/edd_ram.sv =====
// Generic single write port RAM with registered read
module edd_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read first port, register read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/edd_front.sv =====
// Input front end: accepts pixels and queues them for the back end
module edd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           blue_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           red_in,
	input  logic                 frame_start,
	output edd_pkg::qhead_t      head,
	input  logic                 pop
);

	edd_pkg::pix_t                     entries_q [edd_pkg::QUEUE_DEPTH];
	logic [edd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [edd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [edd_pkg::QUEUE_PTR_W:0]     count_q;
	logic                              push;
	edd_pkg::pix_t                     pix_in;

	// Pack the incoming transfer
	always_comb begin
		pix_in.blue        = blue_in;
		pix_in.green       = green_in;
		pix_in.red         = red_in;
		pix_in.frame_start = frame_start;
	end

	assign in_ready   = (count_q != (edd_pkg::QUEUE_PTR_W + 1)'(edd_pkg::QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.pix   = entries_q[rd_ptr_q];

	// Store accepted pixels
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= pix_in;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/edd_back.sv =====
// Back end: error diffusion sequencer, line store and output register
`include "error_diffusion_dither_rgb_top_assert.svh"

module edd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  edd_pkg::cfg_t   cfg,
	input  edd_pkg::qhead_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      blue_out,
	output logic [7:0]      green_out,
	output logic [7:0]      red_out
);

	typedef enum logic [1:0] {ST_TAKE, ST_SUM, ST_QUANT, ST_ERR} state_t;

	state_t             state_q;
	edd_pkg::pix_t      pix_q;
	edd_pkg::col_t      x_q;
	edd_pkg::col_t      col_q;
	edd_pkg::cnt_t      fill_q;
	edd_pkg::err_t      carry_q [edd_pkg::CHANNELS];
	edd_pkg::err_t      diag_q  [edd_pkg::CHANNELS];
	edd_pkg::err_t      hold_q  [edd_pkg::CHANNELS];
	edd_pkg::col_t      hold_col_q;
	logic               hold_vld_q;
	edd_pkg::pix8_t     v_s2    [edd_pkg::CHANNELS];
	edd_pkg::prod_t     u_s2    [edd_pkg::CHANNELS];
	edd_pkg::pix8_t     q_s3    [edd_pkg::CHANNELS];
	edd_pkg::pix8_t     out_q   [edd_pkg::CHANNELS];
	logic               out_valid_q;

	edd_pkg::pix8_t     chan    [edd_pkg::CHANNELS];
	edd_pkg::err_t      line_err[edd_pkg::CHANNELS];
	edd_pkg::sum_t      sum     [edd_pkg::CHANNELS];
	edd_pkg::pix8_t     sat     [edd_pkg::CHANNELS];
	edd_pkg::prod_t     u_next  [edd_pkg::CHANNELS];
	edd_pkg::pix8_t     q_next  [edd_pkg::CHANNELS];
	edd_pkg::err_t      err     [edd_pkg::CHANNELS];
	edd_pkg::err_t      sh7     [edd_pkg::CHANNELS];
	edd_pkg::err_t      sh5     [edd_pkg::CHANNELS];
	edd_pkg::err_t      sh3     [edd_pkg::CHANNELS];
	edd_pkg::err_t      sh1     [edd_pkg::CHANNELS];
	edd_pkg::err_rgb_t  ram_rdata;
	edd_pkg::err_rgb_t  ram_wdata;
	logic               ram_we;
	logic               ram_re;
	edd_pkg::col_t      take_x;
	logic               take_clear;
	logic               wrap;
	logic               fwd;
	logic               in_line;
	logic               out_free;
	logic               row_last;
	edd_pkg::cnt_t      x_next;

	// Share of an error in sixteenths, truncated toward zero
	function automatic edd_pkg::err_t share16(input edd_pkg::err_t e, input logic [2:0] w);
		logic signed [13:0] p;
		logic signed [13:0] p_adj;
		p     = 14'(e) * $signed(14'(w));
		p_adj = p[13] ? (p + 14'sd15) : p;
		return edd_pkg::err_t'(p_adj >>> 4);
	endfunction

	// Next-row error line
	edd_ram #(
		.WIDTH(edd_pkg::LINE_W),
		.DEPTH(edd_pkg::MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(hold_col_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(take_x),
		.rdata(ram_rdata)
	);

	// Column selection when a pixel is taken from the queue
	assign take_clear = head.pix.frame_start;
	assign wrap       = (edd_pkg::cnt_t'(col_q) >= cfg.width);
	assign take_x     = (take_clear || wrap) ? '0 : col_q;
	assign pop        = (state_q == ST_TAKE) && head.valid;
	assign ram_re     = pop;

	// Column bookkeeping for the current pixel
	assign x_next   = edd_pkg::cnt_t'(x_q) + 1'b1;
	assign row_last = (x_next >= cfg.width);
	assign fwd      = hold_vld_q && (hold_col_q == x_q);
	assign in_line  = (edd_pkg::cnt_t'(x_q) < fill_q);
	assign out_free = !out_valid_q || out_ready;
	assign ram_we   = (state_q == ST_ERR) && out_free && hold_vld_q;

	assign chan[0] = pix_q.blue;
	assign chan[1] = pix_q.green;
	assign chan[2] = pix_q.red;

	// Per-channel datapath: sum and saturate, quantise, error shares
	always_comb begin
		for (int c = 0; c < edd_pkg::CHANNELS; c++) begin
			logic [7:0] idx0;
			logic [8:0] rsum;
			logic [7:0] idx;
			if (!in_line) begin
				line_err[c] = '0;
			end else if (fwd) begin
				line_err[c] = hold_q[c];
			end else begin
				line_err[c] = ram_rdata[c];
			end
			sum[c] = $signed({4'b0000, chan[c]}) + edd_pkg::sum_t'(line_err[c])
				+ edd_pkg::sum_t'(carry_q[c]);
			if (sum[c] < 0) begin
				sat[c] = 8'd0;
			end else if (sum[c] > 12'sd255) begin
				sat[c] = 8'd255;
			end else begin
				sat[c] = sum[c][7:0];
			end
			u_next[c] = edd_pkg::prod_t'(cfg.levels) * edd_pkg::prod_t'(sat[c]) + 16'd127;

			// Divide by 255: shift estimate plus one correction
			idx0      = u_s2[c][15:8];
			rsum      = {1'b0, u_s2[c][7:0]} + {1'b0, idx0};
			idx       = idx0 + 8'(rsum >= 9'd255);
			q_next[c] = 8'(edd_pkg::prod_t'(cfg.step) * edd_pkg::prod_t'(idx));

			err[c] = $signed({2'b00, v_s2[c]}) - $signed({2'b00, q_s3[c]});
			sh7[c] = share16(err[c], 3'd7);
			sh5[c] = share16(err[c], 3'd5);
			sh3[c] = share16(err[c], 3'd3);
			sh1[c] = share16(err[c], 3'd1);

			// Lower-left entry gets its last share only when this pixel follows it
			ram_wdata[c] = (x_q != '0) ? (hold_q[c] + sh3[c]) : hold_q[c];
		end
	end

	// Sequencer, error state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			col_q       <= '0;
			fill_q      <= '0;
			hold_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < edd_pkg::CHANNELS; c++) begin
				carry_q[c] <= '0;
				diag_q[c]  <= '0;
			end
		end else begin
			// Drop the taken result unless a new pixel finishes now
			if (out_valid_q && out_ready && (state_q != ST_ERR)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_TAKE: begin
					if (head.valid) begin
						pix_q <= head.pix;
						x_q   <= take_x;
						if (take_clear || wrap) begin
							for (int c = 0; c < edd_pkg::CHANNELS; c++) begin
								carry_q[c] <= '0;
								diag_q[c]  <= '0;
							end
						end
						if (take_clear) begin
							hold_vld_q <= 1'b0;
							fill_q     <= '0;
						end
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					for (int c = 0; c < edd_pkg::CHANNELS; c++) begin
						v_s2[c] <= sat[c];
						u_s2[c] <= u_next[c];
					end
					state_q <= ST_QUANT;
				end
				ST_QUANT: begin
					for (int c = 0; c < edd_pkg::CHANNELS; c++) begin
						q_s3[c] <= q_next[c];
					end
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hold_col_q  <= x_q;
						hold_vld_q  <= 1'b1;
						for (int c = 0; c < edd_pkg::CHANNELS; c++) begin
							out_q[c]   <= q_s3[c];
							hold_q[c]  <= diag_q[c] + sh5[c];
							carry_q[c] <= row_last ? '0 : sh7[c];
							diag_q[c]  <= row_last ? '0 : sh1[c];
						end
						col_q <= row_last ? '0 : edd_pkg::col_t'(x_next);
						if (x_next > fill_q) begin
							fill_q <= x_next;
						end
						state_q <= ST_TAKE;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= ST_TAKE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign blue_out  = out_q[0];
	assign green_out = out_q[1];
	assign red_out   = out_q[2];

	`EDD_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= edd_pkg::FILL_MAX, "fill count beyond line store")
	`EDD_ASSERT_NOW(a_lower_left, (state_q == ST_ERR) && (x_q != '0), hold_vld_q && (hold_col_q == x_q - 1'b1), "lower-left entry not held for this column")
	`EDD_ASSERT_NEXT(a_out_stall, (state_q == ST_ERR) && out_valid_q && !out_ready, state_q == ST_ERR, "pixel finished over an untaken result")

endmodule
